>>> rtl/ppc_pkg.sv
// Package for the particle plane collision unit: widths, codes, stage structs
// and the fixed-point rounding and saturation helpers.
// Depends on nothing; every rtl file imports it.
package ppc_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned DIR_W         = 18;
  localparam int unsigned CLR_W         = 24;
  localparam int unsigned MASS_W        = 31;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 24;
  localparam int unsigned R_W           = 2 * CLR_W;
  localparam int unsigned ROOT_W        = CLR_W;
  localparam int unsigned ROOT_STEPS    = 3;
  localparam int unsigned ROOT_STAGES   = ROOT_W / ROOT_STEPS;
  localparam int unsigned COS_W         = 44;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_DIR_X = 3'd0,
    REG_LINE_DIR_Y = 3'd1,
    REG_NORMAL_X   = 3'd2,
    REG_NORMAL_Y   = 3'd3,
    REG_CLEARANCE  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    HIT_NONE   = 2'd0,
    HIT_PUSH   = 2'd1,
    HIT_BOUNCE = 2'd2
  } hit_t;

  // Front end result: contact decided, cosine prepared for the mirror.
  typedef struct packed {
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic signed [DATA_W-1:0] fx;
    logic signed [DATA_W-1:0] fy;
    logic        [MASS_W-1:0] mass;
    logic        [R_W-1:0]    r;
    logic                     contact;
    logic                     bounce;
    logic signed [DIR_W:0]    sdx;
    logic signed [DIR_W:0]    sdy;
    logic        [COS_W-1:0]  cabs;
  } front_t;

  // Velocity and force final, root still to take.
  typedef struct packed {
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic signed [DATA_W-1:0] fx;
    logic signed [DATA_W-1:0] fy;
    logic        [R_W-1:0]    r;
    logic                     contact;
    logic                     bounce;
  } bnc_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic signed [DATA_W-1:0] fx;
    logic signed [DATA_W-1:0] fy;
    logic                     contact;
    logic                     bounce;
    logic        [ROOT_W-1:0] root;
  } root_t;

  // Round to nearest, ties toward plus infinity, dropping f fraction bits.
  function automatic logic signed [63:0] rnd_q(input logic signed [63:0] v,
                                               input int unsigned f);
    return (v + (64'sd1 <<< (f - 1))) >>> f;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/particle_plane_collision_unit.sv
// Top level of the particle plane collision unit: configuration registers,
// pipeline enable and the four pipeline sections. Uses ppc_pkg and their modules.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one particle word per cycle while
//   in_ready is high: position, velocity, force, mass and its offset from the plane line.
//   Output channel (out_valid/out_ready) returns one corrected word per input
//   word, in order: position, velocity, force and the hit code.
//   Configuration port (cfg_we/cfg_index/cfg_data) writes line direction,
//   normal and clearance; write it only while no word is in flight.
//   The pipeline has 17 stages from input accept to output valid: 3 front stages,
//   4 bounce stages, 8 square-root stages (3 root bits each) and 2 push stages.
//   Throughput is one word per cycle while the receiver takes every output word.
//   All stages advance together. When the receiver stalls with a word held in
//   the output register, the whole pipeline holds, and in_ready drops in the
//   same cycle; nothing is dropped or repeated. in_ready is high whenever the
//   output register is empty or being taken.
//   Synchronous reset clears all stage valid bits and loads the registers with
//   direction (1,0), normal (0,1) and clearance 1.0.
module particle_plane_collision_unit #(
  parameter int unsigned FRAC_BITS = ppc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ppc_pkg::DATA_W-1:0]   in_pos_x,
  input  logic signed [ppc_pkg::DATA_W-1:0]   in_pos_y,
  input  logic signed [ppc_pkg::DATA_W-1:0]   in_vel_x,
  input  logic signed [ppc_pkg::DATA_W-1:0]   in_vel_y,
  input  logic signed [ppc_pkg::DATA_W-1:0]   in_force_x,
  input  logic signed [ppc_pkg::DATA_W-1:0]   in_force_y,
  input  logic        [ppc_pkg::MASS_W-1:0]   in_mass,
  input  logic signed [ppc_pkg::DATA_W-1:0]   in_offset_x,
  input  logic signed [ppc_pkg::DATA_W-1:0]   in_offset_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ppc_pkg::DATA_W-1:0]   out_new_pos_x,
  output logic signed [ppc_pkg::DATA_W-1:0]   out_new_pos_y,
  output logic signed [ppc_pkg::DATA_W-1:0]   out_new_vel_x,
  output logic signed [ppc_pkg::DATA_W-1:0]   out_new_vel_y,
  output logic signed [ppc_pkg::DATA_W-1:0]   out_new_force_x,
  output logic signed [ppc_pkg::DATA_W-1:0]   out_new_force_y,
  output logic        [1:0]                   out_hit,
  input  logic                                cfg_we,
  input  logic        [ppc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [ppc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ppc_pkg::*;

  logic signed [DIR_W-1:0] dir_x_r, dir_y_r, nrm_x_r, nrm_y_r;
  logic        [CLR_W-1:0] clr_r;
  logic        [R_W-1:0]   cl2_r;
  logic                    en;
  logic                    f_v, b_v, r_v;
  front_t                  f_d;
  bnc_t                    b_d;
  root_t                   r_d;
  hit_t                    hit;

  // Advance every stage unless a finished word is held at the output.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_x_r <= DIR_W'(64'sd1 <<< FRAC_BITS);
      dir_y_r <= '0;
      nrm_x_r <= '0;
      nrm_y_r <= DIR_W'(64'sd1 <<< FRAC_BITS);
      clr_r   <= CLR_W'(64'd1 << FRAC_BITS);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LINE_DIR_X: dir_x_r <= cfg_data[DIR_W-1:0];
        REG_LINE_DIR_Y: dir_y_r <= cfg_data[DIR_W-1:0];
        REG_NORMAL_X:   nrm_x_r <= cfg_data[DIR_W-1:0];
        REG_NORMAL_Y:   nrm_y_r <= cfg_data[DIR_W-1:0];
        REG_CLEARANCE:  clr_r   <= cfg_data[CLR_W-1:0];
        default: ;
      endcase
    end
  end

  // Squared clearance for the contact compare, registered from the clearance register.
  always_ff @(posedge clk) begin
    cl2_r <= clr_r * clr_r;
  end

  ppc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(in_valid),
    .pos_x(in_pos_x), .pos_y(in_pos_y), .vel_x(in_vel_x), .vel_y(in_vel_y),
    .force_x(in_force_x), .force_y(in_force_y), .mass(in_mass),
    .offset_x(in_offset_x), .offset_y(in_offset_y),
    .dir_x(dir_x_r), .dir_y(dir_y_r), .nrm_x(nrm_x_r), .nrm_y(nrm_y_r),
    .cl2(cl2_r), .v_o(f_v), .d_o(f_d)
  );

  ppc_bounce #(.FRAC_BITS(FRAC_BITS)) u_bounce (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(f_v), .d_i(f_d), .v_o(b_v), .d_o(b_d)
  );

  ppc_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(b_v), .d_i(b_d), .v_o(r_v), .d_o(r_d)
  );

  ppc_push #(.FRAC_BITS(FRAC_BITS)) u_push (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(r_v), .d_i(r_d),
    .nrm_x(nrm_x_r), .nrm_y(nrm_y_r), .clearance(clr_r),
    .v_o(out_valid), .pos_x(out_new_pos_x), .pos_y(out_new_pos_y),
    .vel_x(out_new_vel_x), .vel_y(out_new_vel_y),
    .force_x(out_new_force_x), .force_y(out_new_force_y), .hit(hit)
  );

  assign out_hit = hit;

endmodule

>>> rtl/ppc_front.sv
// Front stages: offset and velocity dot products, squared offset length,
// behind-plane correction, contact test and cosine. Uses ppc_pkg.
module ppc_front #(
  parameter int unsigned FRAC_BITS = ppc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                v_i,
  input  logic signed [ppc_pkg::DATA_W-1:0]   pos_x,
  input  logic signed [ppc_pkg::DATA_W-1:0]   pos_y,
  input  logic signed [ppc_pkg::DATA_W-1:0]   vel_x,
  input  logic signed [ppc_pkg::DATA_W-1:0]   vel_y,
  input  logic signed [ppc_pkg::DATA_W-1:0]   force_x,
  input  logic signed [ppc_pkg::DATA_W-1:0]   force_y,
  input  logic        [ppc_pkg::MASS_W-1:0]   mass,
  input  logic signed [ppc_pkg::DATA_W-1:0]   offset_x,
  input  logic signed [ppc_pkg::DATA_W-1:0]   offset_y,
  input  logic signed [ppc_pkg::DIR_W-1:0]    dir_x,
  input  logic signed [ppc_pkg::DIR_W-1:0]    dir_y,
  input  logic signed [ppc_pkg::DIR_W-1:0]    nrm_x,
  input  logic signed [ppc_pkg::DIR_W-1:0]    nrm_y,
  input  logic        [ppc_pkg::R_W-1:0]      cl2,
  output logic                                v_o,
  output ppc_pkg::front_t                     d_o
);
  import ppc_pkg::*;

  localparam int unsigned P_W = DATA_W + DIR_W;
  localparam int unsigned S_W = P_W + 1;

  // stage 1
  logic                     v1_r;
  logic signed [DATA_W-1:0] px1_r, py1_r, vx1_r, vy1_r, fx1_r, fy1_r, ox1_r, oy1_r;
  logic        [MASS_W-1:0] m1_r;
  logic signed [P_W-1:0]    on1_r, on2_r, vn1_r, vn2_r, cd1_r, cd2_r;
  logic        [63:0]       sq1_r, sq2_r;
  logic        [DATA_W-1:0] ax, ay;
  // stage 2
  logic                     v2_r;
  logic signed [DATA_W-1:0] px2_r, py2_r, vx2_r, vy2_r, fx2_r, fy2_r, ox2_r, oy2_r;
  logic        [MASS_W-1:0] m2_r;
  logic signed [S_W-1:0]    odot_r, vdot_r, cdot_r;
  logic        [63:0]       rsum_r;
  // stage 3
  logic                     v3_r;
  front_t                   d3_r, d3_nxt;
  logic                     behind;
  logic        [63:0]       r_full;
  logic signed [63:0]       cosq;

  assign ax = offset_x[DATA_W-1] ? DATA_W'(-offset_x) : DATA_W'(offset_x);
  assign ay = offset_y[DATA_W-1] ? DATA_W'(-offset_y) : DATA_W'(offset_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r <= pos_x;   py1_r <= pos_y;
      vx1_r <= vel_x;   vy1_r <= vel_y;
      fx1_r <= force_x; fy1_r <= force_y;
      ox1_r <= offset_x; oy1_r <= offset_y;
      m1_r  <= mass;
      on1_r <= offset_x * nrm_x;
      on2_r <= offset_y * nrm_y;
      vn1_r <= vel_x * nrm_x;
      vn2_r <= vel_y * nrm_y;
      cd1_r <= vel_x * dir_x;
      cd2_r <= vel_y * dir_y;
      sq1_r <= ax * ax;
      sq2_r <= ay * ay;

      px2_r <= px1_r; py2_r <= py1_r;
      vx2_r <= vx1_r; vy2_r <= vy1_r;
      fx2_r <= fx1_r; fy2_r <= fy1_r;
      ox2_r <= ox1_r; oy2_r <= oy1_r;
      m2_r  <= m1_r;
      odot_r <= S_W'(on1_r) + S_W'(on2_r);
      vdot_r <= S_W'(vn1_r) + S_W'(vn2_r);
      cdot_r <= S_W'(cd1_r) + S_W'(cd2_r);
      rsum_r <= sq1_r + sq2_r;

      d3_r <= d3_nxt;
    end
  end

  always_comb begin
    behind = odot_r[S_W-1];
    r_full = behind ? 64'd0 : rsum_r;
    cosq   = rnd_q(64'(cdot_r), FRAC_BITS);

    d3_nxt.px = behind ? sat32(64'(px2_r) - 64'(ox2_r)) : px2_r;
    d3_nxt.py = behind ? sat32(64'(py2_r) - 64'(oy2_r)) : py2_r;
    d3_nxt.vx = vx2_r;
    d3_nxt.vy = vy2_r;
    d3_nxt.fx = fx2_r;
    d3_nxt.fy = fy2_r;
    d3_nxt.mass = m2_r;
    d3_nxt.r = r_full[R_W-1:0];
    d3_nxt.contact = r_full < 64'(cl2);
    d3_nxt.bounce = d3_nxt.contact && (vdot_r[S_W-1] || (vdot_r == '0));
    // flip the axis so the cosine is never negative
    d3_nxt.cabs = cosq[63] ? COS_W'(-cosq) : COS_W'(cosq);
    d3_nxt.sdx = cosq[63] ? -(DIR_W+1)'(dir_x) : (DIR_W+1)'(dir_x);
    d3_nxt.sdy = cosq[63] ? -(DIR_W+1)'(dir_y) : (DIR_W+1)'(dir_y);
  end

  assign v_o = v3_r;
  assign d_o = d3_r;

endmodule

>>> rtl/ppc_bounce.sv
// Bounce stages: for a bouncing word, mirror the velocity about the line,
// subtract the impulse from the force and damp the velocity; other words pass unchanged. Uses ppc_pkg.
module ppc_bounce #(
  parameter int unsigned FRAC_BITS = ppc_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            v_i,
  input  ppc_pkg::front_t d_i,
  output logic            v_o,
  output ppc_pkg::bnc_t   d_o
);
  import ppc_pkg::*;

  localparam logic signed [63:0] DAMP_Q = ((64'sd8 <<< FRAC_BITS) + 64'sd5) / 64'sd10;

  logic                     v4_r, v5_r, v6_r, v7_r;
  front_t                   d4_r, d5_r, d6_r;
  logic signed [63:0]       tx4_r, ty4_r;
  logic signed [DATA_W-1:0] nvx5_r, nvy5_r;
  logic signed [63:0]       pmx6_r, pmy6_r, pdx6_r, pdy6_r;
  bnc_t                     d7_r, d7_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0;
    end else if (en) begin
      v4_r <= v_i; v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d4_r  <= d_i;
      tx4_r <= d_i.sdx * $signed({1'b0, d_i.cabs});
      ty4_r <= d_i.sdy * $signed({1'b0, d_i.cabs});
      d5_r  <= d4_r;
      nvx5_r <= sat32(rnd_q(tx4_r <<< 1, FRAC_BITS) - 64'(d4_r.vx));
      nvy5_r <= sat32(rnd_q(ty4_r <<< 1, FRAC_BITS) - 64'(d4_r.vy));
      d6_r  <= d5_r;
      pmx6_r <= nvx5_r * $signed({1'b0, d5_r.mass});
      pmy6_r <= nvy5_r * $signed({1'b0, d5_r.mass});
      pdx6_r <= nvx5_r * DAMP_Q;
      pdy6_r <= nvy5_r * DAMP_Q;
      d7_r  <= d7_nxt;
    end
  end

  always_comb begin
    d7_nxt.px = d6_r.px;
    d7_nxt.py = d6_r.py;
    d7_nxt.r = d6_r.r;
    d7_nxt.contact = d6_r.contact;
    d7_nxt.bounce = d6_r.bounce;
    if (d6_r.bounce) begin
      d7_nxt.fx = sat32(64'(d6_r.fx) - rnd_q(pmx6_r, FRAC_BITS));
      d7_nxt.fy = sat32(64'(d6_r.fy) - rnd_q(pmy6_r, FRAC_BITS));
      d7_nxt.vx = sat32(rnd_q(pdx6_r, FRAC_BITS));
      d7_nxt.vy = sat32(rnd_q(pdy6_r, FRAC_BITS));
    end else begin
      d7_nxt.fx = d6_r.fx;
      d7_nxt.fy = d6_r.fy;
      d7_nxt.vx = d6_r.vx;
      d7_nxt.vy = d6_r.vy;
    end
  end

  assign v_o = v7_r;
  assign d_o = d7_r;

endmodule

>>> rtl/ppc_isqrt.sv
// Pipelined integer square root of the squared offset length, three result
// bits per stage, with the word riding alongside. Uses ppc_pkg.
module ppc_isqrt (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  ppc_pkg::bnc_t d_i,
  output logic          v_o,
  output ppc_pkg::root_t d_o
);
  import ppc_pkg::*;

  logic             v_r   [ROOT_STAGES];
  logic [R_W-1:0]   rem_r [ROOT_STAGES];
  logic [R_W-1:0]   res_r [ROOT_STAGES];
  bnc_t             pay_r [ROOT_STAGES];

  for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_stage
    logic           v_in;
    logic [R_W-1:0] rem_in, res_in, rem_nxt, res_nxt;
    bnc_t           pay_in;

    if (s == 0) begin : g_first
      assign v_in   = v_i;
      assign rem_in = d_i.r;
      assign res_in = '0;
      assign pay_in = d_i;
    end else begin : g_next
      assign v_in   = v_r[s-1];
      assign rem_in = rem_r[s-1];
      assign res_in = res_r[s-1];
      assign pay_in = pay_r[s-1];
    end

    always_comb begin
      logic [R_W-1:0] bit_v;
      rem_nxt = rem_in;
      res_nxt = res_in;
      for (int j = 0; j < ROOT_STEPS; j++) begin
        bit_v = R_W'(1) << (2 * (ROOT_W - 1 - (s * ROOT_STEPS + j)));
        if (rem_nxt >= res_nxt + bit_v) begin
          rem_nxt = rem_nxt - (res_nxt + bit_v);
          res_nxt = (res_nxt >> 1) + bit_v;
        end else begin
          res_nxt = res_nxt >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        res_r[s] <= res_nxt;
        pay_r[s] <= pay_in;
      end
    end
  end

  assign v_o        = v_r[ROOT_STAGES-1];
  assign d_o.px     = pay_r[ROOT_STAGES-1].px;
  assign d_o.py     = pay_r[ROOT_STAGES-1].py;
  assign d_o.vx     = pay_r[ROOT_STAGES-1].vx;
  assign d_o.vy     = pay_r[ROOT_STAGES-1].vy;
  assign d_o.fx     = pay_r[ROOT_STAGES-1].fx;
  assign d_o.fy     = pay_r[ROOT_STAGES-1].fy;
  assign d_o.contact = pay_r[ROOT_STAGES-1].contact;
  assign d_o.bounce = pay_r[ROOT_STAGES-1].bounce;
  assign d_o.root   = res_r[ROOT_STAGES-1][ROOT_W-1:0];

endmodule

>>> rtl/ppc_push.sv
// Push-out stages: scale the normal by clearance minus root, move the position
// of a word in contact, set the hit code and drive the output register. Uses ppc_pkg.
module ppc_push #(
  parameter int unsigned FRAC_BITS = ppc_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               v_i,
  input  ppc_pkg::root_t                     d_i,
  input  logic signed [ppc_pkg::DIR_W-1:0]   nrm_x,
  input  logic signed [ppc_pkg::DIR_W-1:0]   nrm_y,
  input  logic        [ppc_pkg::CLR_W-1:0]   clearance,
  output logic                               v_o,
  output logic signed [ppc_pkg::DATA_W-1:0]  pos_x,
  output logic signed [ppc_pkg::DATA_W-1:0]  pos_y,
  output logic signed [ppc_pkg::DATA_W-1:0]  vel_x,
  output logic signed [ppc_pkg::DATA_W-1:0]  vel_y,
  output logic signed [ppc_pkg::DATA_W-1:0]  force_x,
  output logic signed [ppc_pkg::DATA_W-1:0]  force_y,
  output ppc_pkg::hit_t                      hit
);
  import ppc_pkg::*;

  localparam int unsigned PU_W = CLR_W + 1;
  localparam int unsigned PR_W = PU_W + DIR_W;

  logic                     va_r, vb_r;
  root_t                    da_r;
  logic signed [PU_W-1:0]   push;
  logic signed [PR_W-1:0]   prx_r, pry_r;
  logic signed [DATA_W-1:0] px_r, py_r, vx_r, vy_r, fx_r, fy_r;
  hit_t                     hit_r, hit_nxt;

  assign push = $signed({1'b0, clearance}) - $signed({1'b0, d_i.root});

  always_comb begin
    if (da_r.bounce) begin
      hit_nxt = HIT_BOUNCE;
    end else if (da_r.contact) begin
      hit_nxt = HIT_PUSH;
    end else begin
      hit_nxt = HIT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= v_i;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      da_r  <= d_i;
      prx_r <= nrm_x * push;
      pry_r <= nrm_y * push;
      px_r  <= da_r.contact ? sat32(64'(da_r.px) + rnd_q(64'(prx_r), FRAC_BITS)) : da_r.px;
      py_r  <= da_r.contact ? sat32(64'(da_r.py) + rnd_q(64'(pry_r), FRAC_BITS)) : da_r.py;
      vx_r  <= da_r.vx;
      vy_r  <= da_r.vy;
      fx_r  <= da_r.fx;
      fy_r  <= da_r.fy;
      hit_r <= hit_nxt;
    end
  end

  assign v_o     = vb_r;
  assign pos_x   = px_r;
  assign pos_y   = py_r;
  assign vel_x   = vx_r;
  assign vel_y   = vy_r;
  assign force_x = fx_r;
  assign force_y = fy_r;
  assign hit     = hit_r;

endmodule

>>> rtl/ppc_chk.sv
// Port-level checker for the particle plane collision unit and its bind.
// Depends on particle_plane_collision_unit and ppc_pkg.
module ppc_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [ppc_pkg::DATA_W-1:0]  out_new_pos_x,
  input logic signed [ppc_pkg::DATA_W-1:0]  out_new_vel_x,
  input logic        [1:0]                  out_hit
);
  import ppc_pkg::*;

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_pos_x)
      && $stable(out_new_vel_x) && $stable(out_hit))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output drain");

  a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit == HIT_NONE || out_hit == HIT_PUSH || out_hit == HIT_BOUNCE))
    else $error("undefined hit code");

endmodule

bind particle_plane_collision_unit ppc_chk u_ppc_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_new_pos_x(out_new_pos_x),
  .out_new_vel_x(out_new_vel_x), .out_hit(out_hit)
);

>>> dv/ppc_collision_checker.sv
// Checker for the particle plane collision unit: mirrors the register writes,
// predicts each corrected particle word and compares it with the output channel.
// Depends on ppc_pkg for widths, register indexes and hit codes.
module ppc_collision_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic signed [ppc_pkg::DATA_W-1:0]     in_pos_x,
  input  logic signed [ppc_pkg::DATA_W-1:0]     in_pos_y,
  input  logic signed [ppc_pkg::DATA_W-1:0]     in_vel_x,
  input  logic signed [ppc_pkg::DATA_W-1:0]     in_vel_y,
  input  logic signed [ppc_pkg::DATA_W-1:0]     in_force_x,
  input  logic signed [ppc_pkg::DATA_W-1:0]     in_force_y,
  input  logic        [ppc_pkg::MASS_W-1:0]     in_mass,
  input  logic signed [ppc_pkg::DATA_W-1:0]     in_offset_x,
  input  logic signed [ppc_pkg::DATA_W-1:0]     in_offset_y,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [ppc_pkg::DATA_W-1:0]     out_new_pos_x,
  input  logic signed [ppc_pkg::DATA_W-1:0]     out_new_pos_y,
  input  logic signed [ppc_pkg::DATA_W-1:0]     out_new_vel_x,
  input  logic signed [ppc_pkg::DATA_W-1:0]     out_new_vel_y,
  input  logic signed [ppc_pkg::DATA_W-1:0]     out_new_force_x,
  input  logic signed [ppc_pkg::DATA_W-1:0]     out_new_force_y,
  input  logic        [1:0]                     out_hit,
  input  logic                                  cfg_we,
  input  logic        [ppc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [ppc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                    fail_count,
  output int                                    pending_count,
  output int                                    hit_seen [3]
);
  import ppc_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint DAMP = ((longint'(8) <<< FB) + 5) / 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] px, py, vx, vy, fx, fy;
    logic [1:0] hit;
  } particle_t;

  longint dir_x, dir_y, nrm_x, nrm_y, clr;
  particle_t corrected_q[$];

  function automatic longint rnd(longint v);
    return (v + (longint'(1) <<< (FB - 1))) >>> FB;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic particle_t predict_collision();
    longint px, py, vx, vy, fx, fy, ox, oy, m, push, dx, dy, cs, nvx, nvy;
    longint unsigned r;
    particle_t p;
    px = in_pos_x; py = in_pos_y; vx = in_vel_x; vy = in_vel_y;
    fx = in_force_x; fy = in_force_y; m = longint'(in_mass);
    ox = in_offset_x; oy = in_offset_y;
    p.hit = HIT_NONE;
    // behind the plane: step back by the offset and treat it as zero
    if (ox * nrm_x + oy * nrm_y < 0) begin
      px = clip32(px - ox); py = clip32(py - oy); ox = 0; oy = 0;
    end
    r = longint'(ox * ox) + longint'(oy * oy);
    if (ox == -64'sd2147483648 && oy == -64'sd2147483648) r = 64'h8000_0000_0000_0000;
    if (r < longint'(clr * clr)) begin
      push = clr - root_floor(r);
      px = clip32(px + rnd(nrm_x * push));
      py = clip32(py + rnd(nrm_y * push));
      p.hit = HIT_PUSH;
      if (vx * nrm_x + vy * nrm_y <= 0) begin
        dx = dir_x; dy = dir_y;
        cs = rnd(dx * vx + dy * vy);
        if (cs < 0) begin
          dx = -dx; dy = -dy; cs = -cs;
        end
        nvx = clip32(rnd(dx * 2 * cs) - vx);
        nvy = clip32(rnd(dy * 2 * cs) - vy);
        fx = clip32(fx - rnd(nvx * m));
        fy = clip32(fy - rnd(nvy * m));
        vx = clip32(rnd(nvx * DAMP));
        vy = clip32(rnd(nvy * DAMP));
        p.hit = HIT_BOUNCE;
      end
    end
    p.px = px[31:0]; p.py = py[31:0]; p.vx = vx[31:0]; p.vy = vy[31:0];
    p.fx = fx[31:0]; p.fy = fy[31:0];
    return p;
  endfunction

  task automatic compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending_count = corrected_q.size();

  always @(posedge clk) begin
    particle_t e;
    if (!rst_n) begin
      dir_x <= 64'sd65536; dir_y <= 0; nrm_x <= 0; nrm_y <= 64'sd65536;
      clr <= 64'sd65536;
      fail_count = 0;
      hit_seen[0] = 0; hit_seen[1] = 0; hit_seen[2] = 0;
      corrected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_LINE_DIR_X: dir_x <= longint'($signed(cfg_data[DIR_W-1:0]));
          REG_LINE_DIR_Y: dir_y <= longint'($signed(cfg_data[DIR_W-1:0]));
          REG_NORMAL_X:   nrm_x <= longint'($signed(cfg_data[DIR_W-1:0]));
          REG_NORMAL_Y:   nrm_y <= longint'($signed(cfg_data[DIR_W-1:0]));
          REG_CLEARANCE:  clr   <= longint'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && in_ready) corrected_q.push_back(predict_collision());
      if (out_valid && out_ready) begin
        if (corrected_q.size() == 0) begin
          $error("output word with no prediction waiting");
          fail_count++;
        end else begin
          e = corrected_q.pop_front();
          compare_field("new_pos_x", e.px, out_new_pos_x);
          compare_field("new_pos_y", e.py, out_new_pos_y);
          compare_field("new_vel_x", e.vx, out_new_vel_x);
          compare_field("new_vel_y", e.vy, out_new_vel_y);
          compare_field("new_force_x", e.fx, out_new_force_x);
          compare_field("new_force_y", e.fy, out_new_force_y);
          compare_field("hit", e.hit, out_hit);
          hit_seen[out_hit % 3]++;
        end
      end
    end
  end

endmodule

>>> dv/tb_particle_plane_collision_unit.sv
// Testbench top for the particle plane collision unit: clock, reset, register
// phases and particle stimulus; the verdict comes from ppc_collision_checker.
// Depends on ppc_pkg, the rtl and dv/ppc_collision_checker.sv.
module tb_particle_plane_collision_unit;
  import ppc_pkg::*;

  localparam int LATENCY = 17;
  localparam int WATCHDOG_LIMIT = 2000;
  // Index outside the register list; the write must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [DATA_W-1:0] in_pos_x, in_pos_y, in_vel_x, in_vel_y;
  logic signed [DATA_W-1:0] in_force_x, in_force_y, in_offset_x, in_offset_y;
  logic [MASS_W-1:0] in_mass;
  logic signed [DATA_W-1:0] out_new_pos_x, out_new_pos_y, out_new_vel_x, out_new_vel_y;
  logic signed [DATA_W-1:0] out_new_force_x, out_new_force_y;
  logic [1:0] out_hit;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending_count;
  int hit_seen [3];
  int idle_cycles = 0;
  int words_sent;

  particle_plane_collision_unit i_dut (.*);
  ppc_collision_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Count cycles where neither channel moves a word; give up when stuck.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !in_valid && pending_count == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stalls before each word, with stall-free stretches.
  initial begin
    int stall;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 0;
      end
      @(negedge clk);
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Hold until every predicted word has come back, then let the pipe drain.
  task automatic drain_pipe();
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Present one word after a random gap; hold it until accepted.
  task automatic send_particle(logic [31:0] px, py, vx, vy, fx, fy, m, ox, oy);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 0;
    end
    @(negedge clk);
    in_valid <= 1;
    in_pos_x <= px; in_pos_y <= py; in_vel_x <= vx; in_vel_y <= vy;
    in_force_x <= fx; in_force_y <= fy; in_mass <= m[MASS_W-1:0];
    in_offset_x <= ox; in_offset_y <= oy;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? $urandom_range(0, 200000)
                                       : -$urandom_range(0, 200000);
      default: return $urandom;
    endcase
  endfunction

  // Random particle, mostly near the plane so contacts and bounces dominate.
  task automatic send_random();
    logic [31:0] ox, oy, m;
    if ($urandom_range(0, 3) != 0) begin
      ox = $signed($urandom_range(0, 262144)) - 131072;
      oy = $signed($urandom_range(0, 262144)) - 131072;
    end else begin
      ox = rnd_word(); oy = rnd_word();
    end
    m = ($urandom_range(0, 3) == 0) ? {1'b0, $urandom} >> 1 : $urandom_range(0, 400000);
    if ($urandom_range(0, 9) == 0) m = 32'h7fffffff;
    send_particle(rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                  m, ox, oy);
  endtask

  task automatic set_plane(int dx, int dy, int nx, int ny, int c);
    write_reg(REG_LINE_DIR_X, CFG_DATA_W'(dx));
    write_reg(REG_LINE_DIR_Y, CFG_DATA_W'(dy));
    write_reg(REG_NORMAL_X, CFG_DATA_W'(nx));
    write_reg(REG_NORMAL_Y, CFG_DATA_W'(ny));
    write_reg(REG_CLEARANCE, CFG_DATA_W'(c));
  endtask

  initial begin
    int burst;
    rst_n = 0; in_valid = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_pos_x = 0; in_pos_y = 0; in_vel_x = 0; in_vel_y = 0;
    in_force_x = 0; in_force_y = 0; in_mass = 0; in_offset_x = 0; in_offset_y = 0;
    words_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed words on the reset plane: no contact, push only, bounce,
    // behind the plane, and the extremes of every field.
    send_particle(0, 0, 0, 0, 0, 0, 0, 0, 32'h00020000);
    send_particle(0, 0, 0, 32'h00010000, 0, 0, 32'h10000, 0, 32'h8000);
    send_particle(0, 0, 32'h10000, -32'sh10000, 0, 0, 32'h10000, 0, 32'h8000);
    send_particle(0, 0, -32'sh10000, -32'sh10000, 0, 0, 32'h10000, 0, 0);
    send_particle(100, 100, 0, -5, 7, 7, 32'h10000, 0, -32'sh4000);
    send_particle(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                  32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0);
    send_particle(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send_particle(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000);
    send_particle(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                  32'hffffffff, 32'hffffffff, 32'h7fffffff, 32'hffffffff, 32'hffffffff);
    send_particle(0, 0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff);
    @(negedge clk);
    in_valid <= 0;
    drain_pipe();

    // Zero clearance: behind-plane correction with no contact.
    set_plane(32'h10000, 0, 0, 32'h10000, 0);
    send_particle(5, 5, 0, -1, 0, 0, 32'h10000, 3, -32'sh20000);
    send_particle(0, 0, 0, 0, 0, 0, 0, 0, 0);
    @(negedge clk);
    in_valid <= 0;
    drain_pipe();

    // Random phases across planes, including non-unit and extreme registers.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_plane(32'h10000, 0, 0, 32'h10000, 32'h10000);
        1: set_plane(-32'sh10000, 0, 0, -32'sh10000, 32'h800000);
        2: set_plane(46341, 46341, -46341, 46341, 32'h20000);
        3: set_plane(0, 32'h10000, 32'h10000, 0, 32'hffffff);
        4: set_plane(32'h1ffff, 32'h20000, 32'h20000, 32'h1ffff, 32'h18000);
        5: set_plane($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 32'h800000));
        6: set_plane(0, -32'sh10000, -32'sh10000, 0, 1);
        default: set_plane(32'h10000, 0, 0, 32'h10000, 32'h40000);
      endcase
      burst = (ph == 7) ? 115 : 75;
      for (int k = 0; k < burst; k++) send_random();
      @(negedge clk);
      in_valid <= 0;
      drain_pipe();
    end
    write_reg(cfg_reg_t'(REG_UNUSED), 24'h123456);

    drain_pipe();
    $display("sent %0d particle words over 10 plane settings", words_sent);
    $display("results: %0d clear, %0d pushed, %0d bounced",
             hit_seen[0], hit_seen[1], hit_seen[2]);
    if (fail_count == 0 && pending_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
rtl/ppc_pkg.sv
rtl/ppc_front.sv
rtl/ppc_bounce.sv
rtl/ppc_isqrt.sv
rtl/ppc_push.sv
rtl/particle_plane_collision_unit.sv
rtl/ppc_chk.sv
dv/ppc_collision_checker.sv
dv/tb_particle_plane_collision_unit.sv
